@@ hdl/ephg_pkg.sv @@
// ----------------------------------------------------------------------------
// ephg_pkg: shared constants for the ellipse phase position generator
// Register indexes, CORDIC widths, gain and arctangent table.
// ----------------------------------------------------------------------------
package ephg_pkg;

  localparam int PHASE_W  = 16;
  localparam int RATE_W   = 20;
  localparam int IDX_W    = 4;
  localparam int STEPS    = 20;
  localparam int CNT_W    = 5;
  localparam int ZW       = 34;  // sine/cosine angle, turns * 2^32, signed
  localparam int TW       = 34;  // sine/cosine, Q4.30 signed
  localparam int PW       = 48;  // radius * trig product
  localparam int AW       = 50;  // arctangent datapath
  localparam int RAD_W    = 13;
  localparam int CTR_W    = 14;

  localparam logic [TW-1:0] GAIN_Q30 = TW'(652032874);
  localparam logic [ZW-1:0] HALF_TURN = ZW'(64'd2147483648);
  localparam logic [ZW-1:0] QUARTER_TURN = ZW'(64'd1073741824);

  localparam logic [2:0] REG_CENTER_X = 3'd0;
  localparam logic [2:0] REG_CENTER_Y = 3'd1;
  localparam logic [2:0] REG_RADIUS_X = 3'd2;
  localparam logic [2:0] REG_RADIUS_Y = 3'd3;
  localparam logic [2:0] REG_TIME_CAP = 3'd4;

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_ADVANCE = 1'b1;

  function automatic logic [ZW-1:0] atan_turn(input logic [CNT_W-1:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      default: v = 32'd0;
    endcase
    return {2'b00, v};
  endfunction

endpackage

@@ hdl/ellipse_phase_position_generator.sv @@
// ----------------------------------------------------------------------------
// ellipse_phase_position_generator
// Per-object phase accumulator with CORDIC position and heading on an ellipse.
// ----------------------------------------------------------------------------
// One word in, one word out. An advance passes through a bit-serial
// rate*time multiply, a sine/cosine CORDIC, a bit-serial radius multiply,
// an atan2 CORDIC and setup/finish states on its way to a result; a load
// skips the multiply and the phase update. The next word is taken once the
// current result has moved to the output register; that result may still
// be waiting on the output then.
module ellipse_phase_position_generator (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // object_index, start_phase, phase_rate, elapsed
  input  logic        s_tuser,   // op
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // object_id, phase_now, pos_x, pos_y, direction
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  typedef enum logic [3:0] {
    IDLE, MUL, ADV, SCI, SC, RM, AI, AT, DONE
  } state_t;

  state_t state;
  logic [ephg_pkg::CNT_W-1:0] cnt;

  logic [ephg_pkg::CTR_W-1:0] center_x, center_y;
  logic [ephg_pkg::RAD_W-1:0] radius_x, radius_y;
  logic [15:0] time_cap;

  logic [ephg_pkg::PHASE_W-1:0] phase_table [16];
  logic [ephg_pkg::RATE_W-1:0]  rate_table  [16];

  logic [ephg_pkg::IDX_W-1:0]   idx;
  logic [ephg_pkg::PHASE_W-1:0] phase;
  logic [ephg_pkg::RATE_W-1:0]  rate;
  logic [15:0] dt;
  logic [35:0] macc;
  logic signed [ephg_pkg::TW-1:0] sx, sy;
  logic signed [ephg_pkg::ZW-1:0] sz;
  logic flip;
  logic [ephg_pkg::RAD_W-1:0] rxs, rys;
  logic signed [ephg_pkg::PW-1:0] p_xc, p_xs, p_ys, p_yc;
  logic signed [ephg_pkg::AW-1:0] ax, ay;
  logic signed [ephg_pkg::ZW-1:0] az;
  logic zero_f;

  // input fields
  logic [3:0]  in_idx;
  logic [15:0] in_start, in_elapsed;
  logic [19:0] in_rate;
  assign in_idx     = s_tdata[3:0];
  assign in_start   = s_tdata[19:4];
  assign in_rate    = s_tdata[39:20];
  assign in_elapsed = s_tdata[55:40];

  assign s_tready  = (state == IDLE);
  assign cfg_ready = 1'b1;

  // combinational helpers
  logic [35:0] madd;
  logic [31:0] rnd;
  logic signed [ephg_pkg::ZW-1:0] z0;
  logic signed [ephg_pkg::TW-1:0] sdx, sdy;
  logic signed [ephg_pkg::AW-1:0] adx, ady;
  logic signed [ephg_pkg::ZW-1:0] at;
  logic signed [ephg_pkg::AW-1:0] ix, iy;
  logic signed [ephg_pkg::PW-1:0] rpx, rpy;
  logic signed [17:0] vx, vy;
  logic [13:0] posx, posy;
  logic [31:0] head_r;

  assign madd = {macc[34:0], 1'b0} + (dt[15] ? {16'd0, rate} : 36'd0);
  assign rnd  = macc[31:0] + 32'h8000;
  assign z0   = ephg_pkg::ZW'($signed({phase, 16'd0}));
  assign at   = $signed(ephg_pkg::atan_turn(cnt));
  assign sdx  = sy >>> cnt;
  assign sdy  = sx >>> cnt;
  assign adx  = ay >>> cnt;
  assign ady  = ax >>> cnt;
  assign ix   = -ephg_pkg::AW'(p_xs);
  assign iy   = ephg_pkg::AW'(p_yc);
  assign rpx  = (p_xc + ephg_pkg::PW'(64'sd536870912)) >>> 30;
  assign rpy  = (p_ys + ephg_pkg::PW'(64'sd536870912)) >>> 30;
  assign vx   = $signed({4'd0, center_x}) + 18'(rpx);
  assign vy   = $signed({4'd0, center_y}) + 18'(rpy);
  assign posx = vx[17] ? 14'd0 : (vx > 18'sd16383 ? 14'd16383 : vx[13:0]);
  assign posy = vy[17] ? 14'd0 : (vy > 18'sd16383 ? 14'd16383 : vy[13:0]);
  assign head_r = (zero_f ? 32'd0 : az[31:0]) + 32'h8000;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      cnt      <= '0;
      m_tvalid <= 1'b0;
      center_x <= 14'd8000;
      center_y <= 14'd5200;
      radius_x <= 13'd5440;
      radius_y <= 13'd3200;
      time_cap <= 16'd3277;
      for (int i = 0; i < 16; i++) begin
        phase_table[i] <= '0;
        rate_table[i]  <= '0;
      end
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          ephg_pkg::REG_CENTER_X: center_x <= cfg_data[13:0];
          ephg_pkg::REG_CENTER_Y: center_y <= cfg_data[13:0];
          ephg_pkg::REG_RADIUS_X: radius_x <= cfg_data[12:0];
          ephg_pkg::REG_RADIUS_Y: radius_y <= cfg_data[12:0];
          ephg_pkg::REG_TIME_CAP: time_cap <= cfg_data;
          default: ;
        endcase
      end
      // DONE holds until the output slot is free, so it always ends valid
      if (state == DONE) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;

      unique case (state)
        IDLE: begin
          if (s_tvalid) begin
            idx <= in_idx;
            cnt <= '0;
            if (s_tuser == ephg_pkg::OP_LOAD) begin
              phase_table[in_idx] <= in_start;
              rate_table[in_idx]  <= in_rate;
              phase <= in_start;
              state <= SCI;
            end else begin
              phase <= phase_table[in_idx];
              rate  <= rate_table[in_idx];
              dt    <= (in_elapsed > time_cap) ? time_cap : in_elapsed;
              macc  <= '0;
              state <= MUL;
            end
          end
        end
        MUL: begin
          macc <= madd;
          dt   <= {dt[14:0], 1'b0};
          cnt  <= cnt + 5'd1;
          if (cnt == 5'd15) state <= ADV;
        end
        ADV: begin
          phase <= phase + rnd[31:16];
          phase_table[idx] <= phase + rnd[31:16];
          state <= SCI;
        end
        SCI: begin
          sx  <= $signed(ephg_pkg::GAIN_Q30);
          sy  <= '0;
          cnt <= '0;
          if (z0 > $signed(ephg_pkg::QUARTER_TURN)) begin
            sz <= z0 - $signed(ephg_pkg::HALF_TURN);
            flip <= 1'b1;
          end else if (z0 < -$signed(ephg_pkg::QUARTER_TURN)) begin
            sz <= z0 + $signed(ephg_pkg::HALF_TURN);
            flip <= 1'b1;
          end else begin
            sz <= z0;
            flip <= 1'b0;
          end
          state <= SC;
        end
        SC: begin
          if (cnt == 5'(ephg_pkg::STEPS)) begin
            if (flip) begin
              sx <= -sx;
              sy <= -sy;
            end
            rxs  <= radius_x;
            rys  <= radius_y;
            p_xc <= '0;
            p_xs <= '0;
            p_ys <= '0;
            p_yc <= '0;
            cnt  <= '0;
            state <= RM;
          end else begin
            if (!sz[ephg_pkg::ZW-1]) begin
              sx <= sx - sdx;
              sy <= sy + sdy;
              sz <= sz - at;
            end else begin
              sx <= sx + sdx;
              sy <= sy - sdy;
              sz <= sz + at;
            end
            cnt <= cnt + 5'd1;
          end
        end
        RM: begin
          // radius bits MSB first
          p_xc <= (p_xc <<< 1) + (rxs[12] ? ephg_pkg::PW'(sx) : '0);
          p_xs <= (p_xs <<< 1) + (rxs[12] ? ephg_pkg::PW'(sy) : '0);
          p_ys <= (p_ys <<< 1) + (rys[12] ? ephg_pkg::PW'(sy) : '0);
          p_yc <= (p_yc <<< 1) + (rys[12] ? ephg_pkg::PW'(sx) : '0);
          rxs <= {rxs[11:0], 1'b0};
          rys <= {rys[11:0], 1'b0};
          cnt <= cnt + 5'd1;
          if (cnt == 5'd12) state <= AI;
        end
        AI: begin
          zero_f <= (ix == '0) && (iy == '0);
          cnt <= '0;
          if (ix < 0) begin
            ax <= -ix;
            ay <= -iy;
            az <= $signed(ephg_pkg::HALF_TURN);
          end else begin
            ax <= ix;
            ay <= iy;
            az <= '0;
          end
          state <= AT;
        end
        AT: begin
          if (!ay[ephg_pkg::AW-1]) begin
            ax <= ax + adx;
            ay <= ay - ady;
            az <= az + at;
          end else begin
            ax <= ax - adx;
            ay <= ay + ady;
            az <= az - at;
          end
          cnt <= cnt + 5'd1;
          if (cnt == 5'(ephg_pkg::STEPS - 1)) state <= DONE;
        end
        DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= {head_r[31:16], posy, posx, phase, idx};
            state    <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second word taken while busy");

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (state == DONE && m_tvalid && !m_tready) |=> (state == DONE && m_tvalid))
    else $error("pending result overwritten");

  a_cordic_count: assert property (@(posedge clk) disable iff (rst)
    (state == AT) |-> (cnt < 5'(ephg_pkg::STEPS)))
    else $error("atan iteration count out of range");

endmodule
